// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is asserted
`define BAT_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error("check failed");

// same check on the block clock and reset
`define BAT_CHECK(lbl, prop) \
	`BAT_ASSERT(lbl, clk, arst_n, prop)

`endif

// ===== hw/rtl/bat_pkg.sv =====
package bat_pkg;

	localparam int DEFAULT_DEPTH = 16;
	localparam int DEFAULT_WORD_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_SORT   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] position;
		logic       descending;
	} cmd_t;

endpackage

// ===== hw/rtl/bat_front.sv =====
module bat_front #(
	parameter int WORD_WIDTH = bat_pkg::DEFAULT_WORD_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   operation,
	input  logic signed [31:0]           item_value,
	input  logic [3:0]                   position,
	input  logic                         descending,
	output logic                         push_valid,
	input  logic                         push_ready,
	output bat_pkg::cmd_t                push_cmd,
	output logic signed [WORD_WIDTH-1:0] push_key
);

	logic                         valid_s1;
	bat_pkg::cmd_t                cmd_s1;
	logic signed [WORD_WIDTH-1:0] key_s1;

	assign req_ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;
	assign push_key   = key_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1.op         <= bat_pkg::op_t'(operation);
			cmd_s1.position   <= position;
			cmd_s1.descending <= descending;
			key_s1            <= WORD_WIDTH'(item_value);
		end
	end

endmodule

// ===== hw/rtl/bat_fifo.sv =====
module bat_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] slot_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = slot_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= !wptr_q;
			end
			if (do_pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/bat_back.sv =====
module bat_back #(
	parameter int DEPTH      = bat_pkg::DEFAULT_DEPTH,
	parameter int WORD_WIDTH = bat_pkg::DEFAULT_WORD_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  bat_pkg::cmd_t                cmd,
	input  logic signed [WORD_WIDTH-1:0] cmd_key,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [2:0]                   status,
	output logic [3:0]                   entry_index,
	output logic signed [31:0]           entry_value,
	output logic [4:0]                   entry_count,
	output logic                         last_result
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_ONE  = 12'b000000000010,
		S_DRD  = 12'b000000000100,
		S_DWR  = 12'b000000001000,
		S_SRD  = 12'b000000010000,
		S_SCMP = 12'b000000100000,
		S_OI   = 12'b000001000000,
		S_OLD  = 12'b000010000000,
		S_IRD  = 12'b000100000000,
		S_ICMP = 12'b001000000000,
		S_PRD  = 12'b010000000000,
		S_PEM  = 12'b100000000000
	} state_t;

	logic signed [WORD_WIDTH-1:0] mem [DEPTH];
	logic signed [WORD_WIDTH-1:0] rd_data_q;

	state_t                       state_q;
	logic [CW-1:0]                fill_q;
	logic [CW-1:0]                i_q;
	logic [CW-1:0]                j_q;
	logic [CW-1:0]                ip1;
	logic signed [WORD_WIDTH-1:0] key_q;
	logic signed [WORD_WIDTH-1:0] cur_q;
	logic                         desc_q;
	logic                         pend_q;
	logic [3:0]                   pend_idx_q;
	bat_pkg::status_t             status_q;
	logic [3:0]                   idx_q;

	logic                         mem_we;
	logic [IW-1:0]                mem_waddr;
	logic signed [WORD_WIDTH-1:0] mem_wdata;
	logic                         mem_re;
	logic [IW-1:0]                mem_raddr;

	logic                         slot_free;
	logic                         emit;
	bat_pkg::status_t             e_status;
	logic [3:0]                   e_idx;
	logic signed [31:0]           e_val;
	logic                         e_last;
	logic                         match;
	logic                         swap;

	logic                         res_valid_q;
	bat_pkg::status_t             res_status_q;
	logic [3:0]                   res_idx_q;
	logic signed [31:0]           res_val_q;
	logic [4:0]                   res_count_q;
	logic                         res_last_q;

	assign ip1       = i_q + CW'(1);
	assign slot_free = !res_valid_q || res_ready;
	assign match     = rd_data_q == key_q;
	assign swap      = desc_q ? (cur_q < rd_data_q) : (rd_data_q < cur_q);
	assign cmd_ready = state_q == S_IDLE;

	assign res_valid   = res_valid_q;
	assign status      = res_status_q;
	assign entry_index = res_idx_q;
	assign entry_value = res_val_q;
	assign entry_count = res_count_q;
	assign last_result = res_last_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = cmd_key;
		mem_re    = 1'b0;
		mem_raddr = '0;
		emit      = 1'b0;
		e_status  = bat_pkg::ST_OK;
		e_idx     = 4'd0;
		e_val     = '0;
		e_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.op == bat_pkg::OP_APPEND && int'(fill_q) < DEPTH) begin
					mem_we    = 1'b1;
					mem_waddr = fill_q[IW-1:0];
				end
			end
			S_ONE: begin
				emit     = slot_free;
				e_status = status_q;
				e_idx    = idx_q;
			end
			S_DRD: begin
				if (ip1 < fill_q) begin
					mem_re    = 1'b1;
					mem_raddr = ip1[IW-1:0];
				end
			end
			S_DWR: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[IW-1:0];
				mem_wdata = rd_data_q;
			end
			S_SRD, S_PRD: begin
				if (i_q < fill_q) begin
					mem_re    = 1'b1;
					mem_raddr = i_q[IW-1:0];
				end
			end
			S_SCMP: begin
				if (match && pend_q) begin
					emit   = slot_free;
					e_idx  = pend_idx_q;
					e_last = 1'b0;
				end
			end
			S_OI: begin
				if (ip1 < fill_q) begin
					mem_re    = 1'b1;
					mem_raddr = i_q[IW-1:0];
				end
			end
			S_IRD: begin
				if (j_q < fill_q) begin
					mem_re    = 1'b1;
					mem_raddr = j_q[IW-1:0];
				end else begin
					mem_we    = 1'b1;
					mem_waddr = i_q[IW-1:0];
					mem_wdata = cur_q;
				end
			end
			S_ICMP: begin
				if (swap) begin
					mem_we    = 1'b1;
					mem_waddr = j_q[IW-1:0];
					mem_wdata = cur_q;
				end
			end
			S_PEM: begin
				emit   = slot_free;
				e_idx  = 4'(i_q);
				e_val  = 32'(rd_data_q);
				e_last = ip1 == fill_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						pend_q <= 1'b0;
						case (cmd.op)
							bat_pkg::OP_APPEND: begin
								if (int'(fill_q) < DEPTH) begin
									fill_q <= fill_q + CW'(1);
								end
								state_q <= S_ONE;
							end
							bat_pkg::OP_DELETE: begin
								if (int'(cmd.position) >= int'(fill_q)) begin
									state_q <= S_ONE;
								end else begin
									state_q <= S_DRD;
								end
							end
							bat_pkg::OP_SEARCH: begin
								state_q <= S_SRD;
							end
							default: begin
								if (fill_q == '0) begin
									state_q <= S_ONE;
								end else begin
									state_q <= S_OI;
								end
							end
						endcase
					end
				end
				S_ONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DRD: begin
					if (ip1 < fill_q) begin
						state_q <= S_DWR;
					end else begin
						fill_q  <= fill_q - CW'(1);
						state_q <= S_ONE;
					end
				end
				S_DWR: begin
					state_q <= S_DRD;
				end
				S_SRD: begin
					if (i_q < fill_q) begin
						state_q <= S_SCMP;
					end else begin
						state_q <= S_ONE;
					end
				end
				S_SCMP: begin
					if (!(match && pend_q && !slot_free)) begin
						if (match) begin
							pend_q <= 1'b1;
						end
						state_q <= S_SRD;
					end
				end
				S_OI: begin
					if (ip1 < fill_q) begin
						state_q <= S_OLD;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_OLD: begin
					state_q <= S_IRD;
				end
				S_IRD: begin
					if (j_q < fill_q) begin
						state_q <= S_ICMP;
					end else begin
						state_q <= S_OI;
					end
				end
				S_ICMP: begin
					state_q <= S_IRD;
				end
				S_PRD: begin
					state_q <= S_PEM;
				end
				S_PEM: begin
					if (slot_free) begin
						if (ip1 == fill_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_PRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q <= e_status;
			res_idx_q    <= e_idx;
			res_val_q    <= e_val;
			res_count_q  <= 5'(fill_q);
			res_last_q   <= e_last;
		end
		case (state_q)
			S_IDLE: begin
				key_q  <= cmd_key;
				desc_q <= cmd.descending;
				idx_q  <= 4'd0;
				i_q    <= '0;
				case (cmd.op)
					bat_pkg::OP_APPEND: begin
						status_q <= (int'(fill_q) < DEPTH) ? bat_pkg::ST_OK : bat_pkg::ST_FULL;
					end
					bat_pkg::OP_DELETE: begin
						status_q <= bat_pkg::ST_BADPOS;
						i_q      <= CW'(cmd.position);
					end
					bat_pkg::OP_SEARCH: begin
						status_q <= bat_pkg::ST_NOTFOUND;
					end
					default: begin
						status_q <= bat_pkg::ST_EMPTY;
					end
				endcase
			end
			S_DRD: begin
				status_q <= bat_pkg::ST_OK;
			end
			S_DWR: begin
				i_q <= ip1;
			end
			S_SRD: begin
				if (pend_q) begin
					status_q <= bat_pkg::ST_OK;
					idx_q    <= pend_idx_q;
				end
			end
			S_SCMP: begin
				if (!(match && pend_q && !slot_free)) begin
					if (match) begin
						pend_idx_q <= 4'(i_q);
					end
					i_q <= ip1;
				end
			end
			S_OI: begin
				if (ip1 < fill_q) begin
					j_q <= ip1;
				end else begin
					i_q <= '0;
				end
			end
			S_OLD: begin
				cur_q <= rd_data_q;
			end
			S_IRD: begin
				if (j_q >= fill_q) begin
					i_q <= ip1;
				end
			end
			S_ICMP: begin
				if (swap) begin
					cur_q <= rd_data_q;
				end
				j_q <= j_q + CW'(1);
			end
			S_PEM: begin
				if (slot_free) begin
					i_q <= ip1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/bounded_array_table_engine.sv =====
// Table of up to DEPTH signed words, one request at a time. A request passes
// through a front register, then a two-entry command queue, to the back end.
// Append and every error reply give a single result; delete reads and writes
// back each entry shifted down; search reads and compares each held entry;
// sort runs a pairwise exchange pass through the table memory, then reads out
// and emits the entries one at a time. The table memory has a single read
// port and a single write port. A stalled result holds the back end; the
// queue and front stage keep taking requests until their three slots are full.
`include "assert_macros.svh"

module bounded_array_table_engine #(
	parameter int DEPTH      = bat_pkg::DEFAULT_DEPTH,
	parameter int WORD_WIDTH = bat_pkg::DEFAULT_WORD_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] item_value,
	input  logic [3:0]         position,
	input  logic               descending,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [2:0]         status,
	output logic [3:0]         entry_index,
	output logic signed [31:0] entry_value,
	output logic [4:0]         entry_count,
	output logic               last_result
);

	localparam int CMDW = $bits(bat_pkg::cmd_t);
	localparam int QW   = CMDW + WORD_WIDTH;

	logic                         push_valid;
	logic                         push_ready;
	bat_pkg::cmd_t                push_cmd;
	logic signed [WORD_WIDTH-1:0] push_key;
	logic                         pop_valid;
	logic                         pop_ready;
	logic [QW-1:0]                pop_data;
	bat_pkg::cmd_t                pop_cmd;
	logic signed [WORD_WIDTH-1:0] pop_key;

	assign pop_cmd = bat_pkg::cmd_t'(pop_data[QW-1:WORD_WIDTH]);
	assign pop_key = pop_data[WORD_WIDTH-1:0];

	bat_front #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.operation  (operation),
		.item_value (item_value),
		.position   (position),
		.descending (descending),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.push_key   (push_key)
	);

	bat_fifo #(
		.W(QW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_cmd, push_key}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bat_back #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (pop_valid),
		.cmd_ready   (pop_ready),
		.cmd         (pop_cmd),
		.cmd_key     (pop_key),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.status      (status),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.entry_count (entry_count),
		.last_result (last_result)
	);

	`BAT_CHECK(a_err_is_last, res_valid && status != bat_pkg::ST_OK |-> last_result)
	`BAT_CHECK(a_status_known, res_valid |-> status <= bat_pkg::ST_EMPTY)
	`BAT_CHECK(a_count_bound, res_valid |-> 32'(entry_count) <= DEPTH)

endmodule

// ===== tb/bounded_array_table_engine_chk.sv =====
module bounded_array_table_engine_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] item_value,
	input  logic [3:0]         position,
	input  logic               descending,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic [2:0]         status,
	input  logic [3:0]         entry_index,
	input  logic signed [31:0] entry_value,
	input  logic [4:0]         entry_count,
	input  logic               last_result,
	output int                 fail_count,
	output int                 pending,
	output int                 result_total
);

	localparam int DEPTH = bat_pkg::DEFAULT_DEPTH;

	typedef struct packed {
		bat_pkg::status_t   st;
		logic [3:0]         idx;
		logic signed [31:0] val;
		logic [4:0]         cnt;
		logic               last;
	} reply_t;

	logic signed [31:0] table_q [DEPTH];
	int                 fill;
	reply_t             expected_replies [$];

	function automatic reply_t mk(bat_pkg::status_t st, int idx, logic signed [31:0] val,
		logic last);
		reply_t r;
		r.st   = st;
		r.idx  = idx[3:0];
		r.val  = val;
		r.cnt  = fill[4:0];
		r.last = last;
		return r;
	endfunction

	task automatic apply_request(bat_pkg::op_t op, logic signed [31:0] v, int pos, logic desc);
		int                 i;
		int                 j;
		int                 first;
		logic signed [31:0] t;
		case (op)
			bat_pkg::OP_APPEND: begin
				if (fill >= DEPTH) begin
					expected_replies.push_back(mk(bat_pkg::ST_FULL, 0, 0, 1'b1));
				end else begin
					table_q[fill] = v;
					fill++;
					expected_replies.push_back(mk(bat_pkg::ST_OK, 0, 0, 1'b1));
				end
			end
			bat_pkg::OP_DELETE: begin
				if (pos >= fill) begin
					expected_replies.push_back(mk(bat_pkg::ST_BADPOS, 0, 0, 1'b1));
				end else begin
					for (i = pos; i + 1 < fill; i++) table_q[i] = table_q[i + 1];
					fill--;
					expected_replies.push_back(mk(bat_pkg::ST_OK, 0, 0, 1'b1));
				end
			end
			bat_pkg::OP_SEARCH: begin
				first = expected_replies.size();
				for (i = 0; i < fill; i++)
					if (table_q[i] == v)
						expected_replies.push_back(mk(bat_pkg::ST_OK, i, 0, 1'b0));
				if (expected_replies.size() == first)
					expected_replies.push_back(mk(bat_pkg::ST_NOTFOUND, 0, 0, 1'b1));
				else
					expected_replies[$].last = 1'b1;
			end
			default: begin
				if (fill == 0) begin
					expected_replies.push_back(mk(bat_pkg::ST_EMPTY, 0, 0, 1'b1));
				end else begin
					for (i = 0; i + 1 < fill; i++)
						for (j = i + 1; j < fill; j++)
							if (desc ? (table_q[i] < table_q[j]) : (table_q[j] < table_q[i])) begin
								t = table_q[i];
								table_q[i] = table_q[j];
								table_q[j] = t;
							end
					for (i = 0; i < fill; i++)
						expected_replies.push_back(mk(bat_pkg::ST_OK, i, table_q[i], i + 1 == fill));
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t e;
		if (!arst_n) begin
			fill = 0;
			fail_count = 0;
			result_total = 0;
			expected_replies.delete();
			pending = 0;
		end else begin
			if (res_valid && res_ready) begin
				result_total++;
				if (expected_replies.size() == 0) begin
					$error("unexpected result: status %0d index %0d", status, entry_index);
					fail_count++;
				end else begin
					e = expected_replies.pop_front();
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						fail_count++;
					end
					if (entry_index !== e.idx) begin
						$error("entry_index: expected %0d, got %0d", e.idx, entry_index);
						fail_count++;
					end
					if (entry_value !== e.val) begin
						$error("entry_value: expected %0d, got %0d", e.val, entry_value);
						fail_count++;
					end
					if (entry_count !== e.cnt) begin
						$error("entry_count: expected %0d, got %0d", e.cnt, entry_count);
						fail_count++;
					end
					if (last_result !== e.last) begin
						$error("last_result: expected %0d, got %0d", e.last, last_result);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready)
				apply_request(bat_pkg::op_t'(operation), item_value, position, descending);
			pending = expected_replies.size();
		end
	end
endmodule

// ===== tb/bounded_array_table_engine_tb.sv =====
module bounded_array_table_engine_tb;

	localparam int LIMIT = 600000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic [1:0]         operation = bat_pkg::OP_APPEND;
	logic signed [31:0] item_value = '0;
	logic [3:0]         position = '0;
	logic               descending = 1'b0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	logic [2:0]         status;
	logic [3:0]         entry_index;
	logic signed [31:0] entry_value;
	logic [4:0]         entry_count;
	logic               last_result;
	int                 fail_count;
	int                 pending;
	int                 result_total;
	int                 cycles = 0;
	int                 sent = 0;
	int                 burst_left = 0;
	int                 fill_guess = 0;
	int                 stall_mode = 0;
	logic signed [31:0] recent [$];

	always #6 clk = ~clk;

	bounded_array_table_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .item_value(item_value),
		.position(position), .descending(descending),
		.res_valid(res_valid), .res_ready(res_ready),
		.status(status), .entry_index(entry_index), .entry_value(entry_value),
		.entry_count(entry_count), .last_result(last_result)
	);

	bounded_array_table_engine_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .item_value(item_value),
		.position(position), .descending(descending),
		.res_valid(res_valid), .res_ready(res_ready),
		.status(status), .entry_index(entry_index), .entry_value(entry_value),
		.entry_count(entry_count), .last_result(last_result),
		.fail_count(fail_count), .pending(pending), .result_total(result_total)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("bounded_array_table_engine regression: fail");
			$finish;
		end
	end

	// receiver stall pattern: phases of always-ready, random, and mostly-stalled
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= 1'($urandom_range(0, 1));
			default: res_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 7) - 4;
			3: if (recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
			   else return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(bat_pkg::op_t op, logic signed [31:0] v, logic [3:0] pos, logic desc);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid  <= 1'b1;
		operation  <= op;
		item_value <= v;
		position   <= pos;
		descending <= desc;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
		sent++;
		if (op == bat_pkg::OP_APPEND) begin
			if (fill_guess < bat_pkg::DEFAULT_DEPTH) fill_guess++;
			recent.push_back(v);
			if (recent.size() > 8) void'(recent.pop_front());
		end else if (op == bat_pkg::OP_DELETE && pos < fill_guess) begin
			fill_guess--;
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int           k;
		int           r;
		bat_pkg::op_t op;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		send(bat_pkg::OP_SORT, 0, 0, 0);
		send(bat_pkg::OP_SEARCH, 5, 0, 0);
		send(bat_pkg::OP_DELETE, 0, 0, 0);
		for (k = 0; k < 17; k++)
			send(bat_pkg::OP_APPEND, k == 0 ? 32'sh80000000 : k == 1 ? 32'sh7fffffff :
				(k % 3 == 0 ? -7 : k * 1000 - 5000), 0, 0);
		send(bat_pkg::OP_SEARCH, -7, 0, 0);
		send(bat_pkg::OP_SORT, 0, 0, 1);
		send(bat_pkg::OP_SORT, 0, 0, 0);
		send(bat_pkg::OP_DELETE, 4'hf, 4'hf, 0);
		send(bat_pkg::OP_DELETE, 0, 4'hf, 0);
		drain();

		while (sent < 370) begin
			if (sent == 200) drain();
			r = $urandom_range(0, 99);
			if (fill_guess >= bat_pkg::DEFAULT_DEPTH - 2 && r < 40) op = bat_pkg::OP_DELETE;
			else if (r < 40) op = bat_pkg::OP_APPEND;
			else if (r < 65) op = bat_pkg::OP_DELETE;
			else if (r < 88) op = bat_pkg::OP_SEARCH;
			else op = bat_pkg::OP_SORT;
			send(op, pick_value(),
				4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) :
				$urandom_range(0, fill_guess > 0 ? fill_guess - 1 : 0)),
				1'($urandom_range(0, 1)));
		end

		req_valid <= 1'b0;
		k = 0;
		while (pending != 0 && k < 200000) begin
			@(negedge clk);
			k++;
		end
		repeat (400) @(negedge clk);
		$display("covered %0d requests producing %0d results over %0d cycles",
			sent, result_total, cycles);
		$display("operations: append, delete, search, sort both orders; full and empty table");
		if (fail_count == 0 && pending == 0) begin
			$display("bounded_array_table_engine regression: pass");
		end else begin
			$display("bounded_array_table_engine regression: fail");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bat_pkg.sv
hw/rtl/bat_front.sv
hw/rtl/bat_fifo.sv
hw/rtl/bat_back.sv
hw/rtl/bounded_array_table_engine.sv
tb/bounded_array_table_engine_chk.sv
tb/bounded_array_table_engine_tb.sv
